>>> hdl/sawc_pkg.sv
// Shared types, constants and helper functions for the set-associative
// write-back cache controller. No dependencies.
package sawc_pkg;

   localparam int DEF_SETS        = 64;
   localparam int DEF_WAYS        = 4;
   localparam int DEF_BLOCK_BYTES = 32;

   localparam int ADDR_W  = 32;
   localparam int STAMP_W = 32;
   localparam int ACT_W   = 2;

   localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_INVAL = 2'd2;
   localparam logic [ACT_W-1:0] ACT_RSVD  = 2'd3;

   localparam logic CSR_REPLACE_POLICY = 1'b0;
   localparam logic CSR_INCLUSIVE_MODE = 1'b1;

   localparam logic POLICY_LRU = 1'b0;

   typedef struct packed {
      logic accept;   // load request, start tag/stamp read
      logic commit;   // update state, load result register
   } sawc_cmd_type;

   function automatic int floor_log2(input int n);
      int r;
      int v;
      r = 0;
      v = n;
      while (v > 1) begin
         v = v >> 1;
         r = r + 1;
      end
      return r;
   endfunction

endpackage

>>> hdl/sawc_ctrl.sv
// Control state machine of the cache controller: request acceptance,
// commit timing and the result handshake. Depends on sawc_pkg.
module sawc_ctrl
   import sawc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output sawc_cmd_type cmd
);

   typedef enum logic {ST_IDLE, ST_LOOKUP} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.accept = (state_ff == ST_IDLE) && req_tvalid;
      cmd.commit = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            // hold until the result register can take the transaction
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hdl/sawc_dp.sv
// Datapath of the cache controller: tag and stamp memories, valid and dirty
// bits, hit and victim logic, stamp counter and result register. Uses sawc_pkg.
module sawc_dp
   import sawc_pkg::*;
#(
   parameter int SETS        = DEF_SETS,
   parameter int WAYS        = DEF_WAYS,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  sawc_cmd_type       cmd,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [ADDR_W-1:0]  req_addr,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic               csr_wdata,
   output logic               rsp_hit,
   output logic               rsp_fill_request,
   output logic               rsp_writeback,
   output logic               rsp_back_invalidate,
   output logic [ADDR_W-1:0]  rsp_evict_addr,
   output logic               rsp_removed_dirty
);

   localparam int OB = floor_log2(BLOCK_BYTES);
   localparam int IB = floor_log2(SETS);
   localparam int TW = ADDR_W - OB - IB;
   localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WP = 1 << $clog2(WAYS);

   logic [WAYS*TW-1:0]      tag_mem   [SETS];
   logic [WAYS*STAMP_W-1:0] stamp_mem [SETS];
   logic [WAYS-1:0]         valid_ff  [SETS];
   logic [WAYS-1:0]         dirty_ff  [SETS];

   logic [WAYS*TW-1:0]      tag_rd_ff;
   logic [WAYS*STAMP_W-1:0] stamp_rd_ff;
   logic [ACT_W-1:0]        act_ff;
   logic [TW-1:0]           tag_ff;
   logic [SW-1:0]           set_ff;
   logic [STAMP_W-1:0]      counter_ff;
   logic                    policy_ff;
   logic                    incl_ff;

   logic [ADDR_W-1:0]       set_full;
   logic [SW-1:0]           req_set;

   // lookup results
   logic [WAYS-1:0]         vrow, drow, match;
   logic                    found, has_empty;
   logic [WW-1:0]           hit_way, empty_way, lru_way, sel_way;
   logic [STAMP_W-1:0]      node_stamp [2*WP];
   logic [WW-1:0]           node_way   [2*WP];
   logic                    node_ok    [2*WP];
   logic [WAYS-1:0]         vrow_in, drow_in;
   logic [WAYS*TW-1:0]      tag_row_in;
   logic [WAYS*STAMP_W-1:0] stamp_row_in;
   logic                    restamp;
   logic [STAMP_W-1:0]      counter_inc;
   logic [TW-1:0]           vtag;
   logic                    r_hit, r_fill, r_wb, r_binv, r_wdirty;
   logic [ADDR_W-1:0]       r_vaddr;

   assign set_full = (req_addr >> OB) & ADDR_W'(SETS - 1);
   assign req_set  = set_full[SW-1:0];
   assign counter_inc = counter_ff + STAMP_W'(1);

   always_comb begin
      vrow      = valid_ff[set_ff];
      drow      = dirty_ff[set_ff];
      found     = 1'b0;
      has_empty = 1'b0;
      hit_way   = '0;
      empty_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match[w] = vrow[w] && (tag_rd_ff[w*TW +: TW] == tag_ff);
         if (match[w]) begin
            found   = 1'b1;
            hit_way = WW'(w);
         end
         if (!vrow[w]) begin
            has_empty = 1'b1;
            empty_way = WW'(w);
         end
      end

      // smallest stamp tournament; the left (lower) way wins ties
      for (int n = 0; n < 2*WP; n++) begin
         node_stamp[n] = '0;
         node_way[n]   = '0;
         node_ok[n]    = 1'b0;
      end
      for (int w = 0; w < WP; w++) begin
         if (w < WAYS) begin
            node_stamp[WP+w] = stamp_rd_ff[w*STAMP_W +: STAMP_W];
            node_way[WP+w]   = WW'(w);
            node_ok[WP+w]    = 1'b1;
         end
      end
      for (int n = WP - 1; n >= 1; n--) begin
         if (node_ok[2*n] && (!node_ok[2*n+1] || node_stamp[2*n] <= node_stamp[2*n+1])) begin
            node_stamp[n] = node_stamp[2*n];
            node_way[n]   = node_way[2*n];
            node_ok[n]    = node_ok[2*n];
         end else begin
            node_stamp[n] = node_stamp[2*n+1];
            node_way[n]   = node_way[2*n+1];
            node_ok[n]    = node_ok[2*n+1];
         end
      end
      lru_way = node_way[1];

      vrow_in      = vrow;
      drow_in      = drow;
      tag_row_in   = tag_rd_ff;
      stamp_row_in = stamp_rd_ff;
      restamp      = 1'b0;
      sel_way      = hit_way;
      vtag         = tag_rd_ff[lru_way*TW +: TW];
      r_hit        = 1'b0;
      r_fill       = 1'b0;
      r_wb         = 1'b0;
      r_binv       = 1'b0;
      r_wdirty     = 1'b0;
      r_vaddr      = '0;

      case (act_ff) inside
         ACT_INVAL: begin
            if (found) begin
               r_hit            = 1'b1;
               r_wdirty         = drow[hit_way];
               vrow_in[hit_way] = 1'b0;
               drow_in[hit_way] = 1'b0;
            end
         end
         ACT_READ, ACT_WRITE: begin
            if (found) begin
               r_hit = 1'b1;
               if (act_ff == ACT_WRITE) drow_in[hit_way] = 1'b1;
               restamp = (policy_ff == POLICY_LRU);
            end else begin
               r_fill = 1'b1;
               if (has_empty) begin
                  sel_way = empty_way;
               end else begin
                  sel_way = lru_way;
                  r_vaddr = {vtag, {(ADDR_W-TW){1'b0}}} | (ADDR_W'(set_ff) << OB);
                  r_wb    = drow[lru_way];
                  r_binv  = incl_ff;
               end
               vrow_in[sel_way]               = 1'b1;
               drow_in[sel_way]               = (act_ff == ACT_WRITE);
               tag_row_in[sel_way*TW +: TW]   = tag_ff;
               restamp                        = 1'b1;
            end
            if (restamp) stamp_row_in[sel_way*STAMP_W +: STAMP_W] = counter_inc;
         end
         default: ;
      endcase
   end

   // tag and stamp memories: read on accept, write on commit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tag_rd_ff   <= tag_mem[req_set];
         stamp_rd_ff <= stamp_mem[req_set];
         act_ff      <= req_action;
         tag_ff      <= req_addr[ADDR_W-1 -: TW];
         set_ff      <= req_set;
      end
      if (cmd.commit) begin
         tag_mem[set_ff]     <= tag_row_in;
         stamp_mem[set_ff]   <= stamp_row_in;
         rsp_hit             <= r_hit;
         rsp_fill_request    <= r_fill;
         rsp_writeback       <= r_wb;
         rsp_back_invalidate <= r_binv;
         rsp_evict_addr      <= r_vaddr;
         rsp_removed_dirty   <= r_wdirty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
            dirty_ff[s] <= '0;
         end
         counter_ff <= '0;
         policy_ff  <= 1'b0;
         incl_ff    <= 1'b0;
      end else begin
         if (cmd.commit) begin
            valid_ff[set_ff] <= vrow_in;
            dirty_ff[set_ff] <= drow_in;
            if (restamp) counter_ff <= counter_inc;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_REPLACE_POLICY: policy_ff <= csr_wdata;
               CSR_INCLUSIVE_MODE: incl_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> hdl/set_assoc_writeback_cache_ctrl.sv
// Set-associative write-back cache tag/state controller.
// Request channel (req_*): tuser carries the action (read, write,
// invalidate line), tdata the 32-bit byte address. One result per request
// leaves on the response channel (rsp_*) with hit, fill, writeback,
// back-invalidate, victim block address and was-dirty flags.
// Per request, the set's tag and stamp rows are read from memory on
// acceptance in the idle state; in the lookup state the controller compares
// the ways, picks the victim, writes the row back and loads the result
// register. A new request is taken in the cycle after the result is
// loaded, even while that result still waits on the response channel.
// Stalls: when the result register is still occupied, the lookup holds
// until rsp_tready drains it; nothing is lost or repeated.
// Reset: synchronous; clears all valid and dirty bits at once, the stamp
// counter and both configuration registers (LRU, non-inclusive). No
// clearing pass is needed; the block is ready the cycle after reset.
// Configuration: csr_we with csr_index 0 (policy) or 1 (inclusive mode).
// Depends on sawc_pkg, sawc_ctrl, sawc_dp.
module set_assoc_writeback_cache_ctrl
   import sawc_pkg::*;
#(
   parameter int SETS        = DEF_SETS,
   parameter int WAYS        = DEF_WAYS,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] req_addr
   input  logic [1:0]   req_tuser,   // [1:0] action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] hit, [1] fill_request, [2] writeback, [3] back_invalidate,
   // [35:4] evict_addr, [36] removed_dirty, [39:37] zero
   output logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic         csr_wdata
);

   sawc_cmd_type      cmd;
   logic              hit, fill, wb, binv, wdirty;
   logic [ADDR_W-1:0] vaddr;

   sawc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sawc_dp #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_action          (req_tuser),
      .req_addr            (req_tdata),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_hit             (hit),
      .rsp_fill_request    (fill),
      .rsp_writeback       (wb),
      .rsp_back_invalidate (binv),
      .rsp_evict_addr      (vaddr),
      .rsp_removed_dirty   (wdirty)
   );

   assign rsp_tdata = {3'b000, wdirty, vaddr, binv, wb, fill, hit};

endmodule
